### rtl/core/qvr_pkg.sv
// qvr_pkg: shared types and constants for the quaternion vector rotate core.
// Defines the pipeline stage words and stage-count constants; no dependencies.
package qvr_pkg;

    localparam int QW      = 16;            // quaternion component width
    localparam int VW      = 24;            // vector component width
    localparam int QBITS   = 25;            // quotient bits kept by the divider
    localparam int DIVSTG  = QBITS + 1;     // range check plus one stage per bit
    localparam int DIV0    = 5;             // index of the first divider stage
    localparam int NSTG    = DIV0 + DIVSTG + 1;
    localparam int RW      = 60;            // dividend / remainder width
    localparam int DW      = 34;            // divisor width (2 * norm)
    localparam logic [QBITS-1:0] POS_MAX = 25'd8388607;
    localparam logic [QBITS-1:0] NEG_MAX = 25'd8388608;

    // accepted word, unpacked
    typedef struct packed {
        logic signed [QW-1:0]     w;
        logic signed [2:0][QW-1:0] u;   // x, y, z
        logic signed [2:0][VW-1:0] v;
    } in_t;

    // first products
    typedef struct packed {
        logic signed [2*QW-1:0]      ww;
        logic signed [2:0][2*QW-1:0] uu;     // x*x, y*y, z*z
        logic signed [2:0][QW+VW-1:0] uv;    // x*vx, y*vy, z*vz
        logic signed [2:0][QW+VW-1:0] cp;    // y*vz, z*vx, x*vy
        logic signed [2:0][QW+VW-1:0] cm;    // z*vy, x*vz, y*vx
        logic signed [QW-1:0]        w;
        logic signed [2:0][QW-1:0]   u;
        logic signed [2:0][VW-1:0]   v;
    } prod_t;

    // sums of products
    typedef struct packed {
        logic signed [33:0]        n;
        logic signed [33:0]        s;
        logic signed [41:0]        d;
        logic signed [2:0][41:0]   c;
        logic signed [QW-1:0]      w;
        logic signed [2:0][QW-1:0] u;
        logic signed [2:0][VW-1:0] v;
    } sum_t;

    // second products
    typedef struct packed {
        logic signed [33:0]        n;
        logic signed [2:0][57:0]   sv;
        logic signed [2:0][57:0]   du;
        logic signed [2:0][57:0]   wc;
    } prod2_t;

    // numerators
    typedef struct packed {
        logic signed [33:0]        n;
        logic signed [2:0][59:0]   num;
    } num_t;

    // divider word
    typedef struct packed {
        logic [2:0][RW-1:0]    rem;
        logic [2:0][QBITS-1:0] quo;
        logic [2:0]            ovf;
        logic [2:0]            neg;
        logic [DW-1:0]         den;
        logic                  zero;
    } div_t;

endpackage

### rtl/core/quaternion_vector_rotate_core.sv
// quaternion_vector_rotate_core: rotates a Q12.12 vector by a Q2.14 quaternion,
// v' = q (0,v) q^-1, divided by the squared norm. Depends on qvr_pkg.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_*     | in  | quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z | -
//  m_*     | out | rot_x, rot_y, rot_z                             | zero_quat, clipped
//
// The path from the accepting edge to m_tvalid runs over 32 registers: the input
// register, four arithmetic stages, a 26-stage restoring divider (range check
// plus one quotient bit per stage), and the output register. One word per cycle
// is sustained while m_tready is high; the divider's per-stage compare/subtract
// sets the clock. Each stage holds when full and the one after it is held, so
// bubbles close up while m_tready is low. rst_n clears valid bits only.
module quaternion_vector_rotate_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // rot_x, rot_y, rot_z
    output logic [1:0]   m_tuser    // zero_quat, clipped
);
    import qvr_pkg::*;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    in_t    in_reg,    in_next;
    prod_t  prod_reg,  prod_next;
    sum_t   sum_reg,   sum_next;
    prod2_t prod2_reg, prod2_next;
    num_t   num_reg,   num_next;
    div_t   div_reg  [DIVSTG];
    div_t   div_next [DIVSTG];
    logic [2:0][VW-1:0] rot_reg, rot_next;
    logic zero_reg, zero_next;
    logic clip_reg, clip_next;

    // stall chain: a stage loads when empty or when its successor moves
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG-2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];

    // unpack input word
    always_comb
    begin
        in_next.w    = s_tdata[15:0];
        in_next.u[0] = s_tdata[31:16];
        in_next.u[1] = s_tdata[47:32];
        in_next.u[2] = s_tdata[63:48];
        in_next.v[0] = s_tdata[87:64];
        in_next.v[1] = s_tdata[111:88];
        in_next.v[2] = s_tdata[135:112];
    end

    // first products (array elements are unsigned selects, so re-sign them)
    always_comb
    begin
        prod_next.ww = 32'(in_reg.w) * 32'(in_reg.w);
        for (int c = 0; c < 3; c++)
        begin
            prod_next.uu[c] = 32'($signed(in_reg.u[c])) * 32'($signed(in_reg.u[c]));
            prod_next.uv[c] = 40'($signed(in_reg.u[c])) * 40'($signed(in_reg.v[c]));
            prod_next.cp[c] = 40'($signed(in_reg.u[(c+1)%3]))
                            * 40'($signed(in_reg.v[(c+2)%3]));
            prod_next.cm[c] = 40'($signed(in_reg.u[(c+2)%3]))
                            * 40'($signed(in_reg.v[(c+1)%3]));
        end
        prod_next.w = in_reg.w;
        prod_next.u = in_reg.u;
        prod_next.v = in_reg.v;
    end

    // norm, scalar term, dot and cross products
    always_comb
    begin
        logic signed [33:0] uu;
        uu = 34'(prod_reg.uu[0]) + 34'(prod_reg.uu[1]) + 34'(prod_reg.uu[2]);
        sum_next.n = 34'(prod_reg.ww) + uu;
        sum_next.s = 34'(prod_reg.ww) - uu;
        sum_next.d = 42'($signed(prod_reg.uv[0])) + 42'($signed(prod_reg.uv[1]))
                   + 42'($signed(prod_reg.uv[2]));
        for (int c = 0; c < 3; c++)
        begin
            sum_next.c[c] = 42'($signed(prod_reg.cp[c])) - 42'($signed(prod_reg.cm[c]));
        end
        sum_next.w = prod_reg.w;
        sum_next.u = prod_reg.u;
        sum_next.v = prod_reg.v;
    end

    // second products
    always_comb
    begin
        prod2_next.n = sum_reg.n;
        for (int c = 0; c < 3; c++)
        begin
            prod2_next.sv[c] = 58'(sum_reg.s) * 58'($signed(sum_reg.v[c]));
            prod2_next.du[c] = 58'(sum_reg.d) * 58'($signed(sum_reg.u[c]));
            prod2_next.wc[c] = 58'($signed(sum_reg.c[c])) * 58'(sum_reg.w);
        end
    end

    // numerators
    always_comb
    begin
        num_next.n = prod2_reg.n;
        for (int c = 0; c < 3; c++)
        begin
            num_next.num[c] = 60'($signed(prod2_reg.sv[c]))
                            + (60'($signed(prod2_reg.du[c])) <<< 1)
                            + (60'($signed(prod2_reg.wc[c])) <<< 1);
        end
    end

    // divider: dividend 2|num|+n, divisor 2n, then one quotient bit per stage
    always_comb
    begin
        logic [RW-1:0] mag;
        logic [RW-1:0] dvd;
        logic [RW-1:0] sh;
        div_next[0].den  = {num_reg.n[DW-2:0], 1'b0};
        div_next[0].zero = (num_reg.n == '0);
        for (int c = 0; c < 3; c++)
        begin
            div_next[0].neg[c] = num_reg.num[c][59];
            mag = num_reg.num[c][59] ? RW'(-num_reg.num[c]) : RW'(num_reg.num[c]);
            dvd = {mag[RW-2:0], 1'b0} + RW'(unsigned'(num_reg.n));
            div_next[0].rem[c] = dvd;
            div_next[0].quo[c] = '0;
            div_next[0].ovf[c] = (dvd >= (RW'(div_next[0].den) << QBITS));
        end
        for (int j = 1; j < DIVSTG; j++)
        begin
            div_next[j] = div_reg[j-1];
            for (int c = 0; c < 3; c++)
            begin
                sh = RW'(div_reg[j-1].den) << (QBITS - j);
                if (div_reg[j-1].rem[c] >= sh)
                begin
                    div_next[j].rem[c]          = div_reg[j-1].rem[c] - sh;
                    div_next[j].quo[c][QBITS-j] = 1'b1;
                end
            end
        end
    end

    // sign, saturation and zero-norm override
    always_comb
    begin
        div_t dl;
        dl        = div_reg[DIVSTG-1];
        clip_next = 1'b0;
        zero_next = dl.zero;
        for (int c = 0; c < 3; c++)
        begin
            if (dl.zero)
            begin
                rot_next[c] = '0;
            end
            else if (!dl.neg[c])
            begin
                if (dl.ovf[c] || dl.quo[c] > POS_MAX)
                begin
                    rot_next[c] = {1'b0, {(VW-1){1'b1}}};
                    clip_next   = 1'b1;
                end
                else
                begin
                    rot_next[c] = dl.quo[c][VW-1:0];
                end
            end
            else
            begin
                if (dl.ovf[c] || dl.quo[c] > NEG_MAX)
                begin
                    rot_next[c] = {1'b1, {(VW-1){1'b0}}};
                    clip_next   = 1'b1;
                end
                else
                begin
                    rot_next[c] = VW'(-dl.quo[c]);
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en[0])      in_reg    <= in_next;
        if (en[1])      prod_reg  <= prod_next;
        if (en[2])      sum_reg   <= sum_next;
        if (en[3])      prod2_reg <= prod2_next;
        if (en[4])      num_reg   <= num_next;
        for (int j = 0; j < DIVSTG; j++)
        begin
            if (en[DIV0+j]) div_reg[j] <= div_next[j];
        end
        if (en[NSTG-1])
        begin
            rot_reg  <= rot_next;
            zero_reg <= zero_next;
            clip_reg <= clip_next;
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {rot_reg[2], rot_reg[1], rot_reg[0]};
    assign m_tuser  = {clip_reg, zero_reg};

    // zero norm gives zero vector and no clip
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && zero_reg |-> rot_reg == '0 && !clip_reg)
        else $error("zero quaternion result not cleared");

    // an empty input stage always takes a word
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> s_tready)
        else $error("input stage empty but not ready");

    // a clip means some component sits at a rail
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && clip_reg |->
            rot_reg[0] == {1'b0, {(VW-1){1'b1}}} || rot_reg[0] == {1'b1, {(VW-1){1'b0}}} ||
            rot_reg[1] == {1'b0, {(VW-1){1'b1}}} || rot_reg[1] == {1'b1, {(VW-1){1'b0}}} ||
            rot_reg[2] == {1'b0, {(VW-1){1'b1}}} || rot_reg[2] == {1'b1, {(VW-1){1'b0}}})
        else $error("clip flag without saturated component");

endmodule
